FILE: rtl/sgi_pkg.sv
// ----------------------------------------------------------------------------
// sgi_pkg: shared widths and types for the segment intersection block
// Widths of line terms, determinant and numerators; the word that moves
// through the divider chain.
// ----------------------------------------------------------------------------
package sgi_pkg;

    // coordinate width, 8 fraction bits
    localparam int W  = 24;
    // line term C = A*x + B*y
    localparam int CW = 2 * W + 2;
    // determinant
    localparam int DW = 2 * W + 3;
    // numerators of X and Y
    localparam int NW = 3 * W + 4;
    // split point of C for the partial products
    localparam int L  = W + 1;

    // coordinates: ax0, ay0, ax1, ay1, bx0, by0, bx1, by1
    typedef logic [7:0][W-1:0] t_coords;

    // word handed from cell to cell in the divider chain
    typedef struct packed {
        t_coords         c;
        logic            dz;   // determinant zero
        logic            sx;   // sign of X
        logic            sy;   // sign of Y
        logic            ox;   // |X| does not fit the quotient width
        logic            oy;
        logic [NW-1:0]   ds;   // shifted divisor
        logic [NW-1:0]   px;   // partial remainder of |nx|
        logic [NW-1:0]   py;
        logic [W-1:0]    qx;   // quotient magnitude bits so far
        logic [W-1:0]    qy;
    } t_div;

endpackage

FILE: rtl/sgi_front.sv
// ----------------------------------------------------------------------------
// sgi_front: line equations, determinant and numerators
// Six registered stages with per-stage flow control; produces the sign,
// magnitudes and overflow flags that enter the divider chain.
// ----------------------------------------------------------------------------
module sgi_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  sgi_pkg::t_coords i_c,
    output logic            o_valid,
    input  logic            i_ready,
    output sgi_pkg::t_div   o_data
);
    import sgi_pkg::*;

    localparam int NS = 6;

    logic [NS-1:0] r_v;
    logic [NS-1:0] mv;

    // stage registers
    t_coords r_s1_c, r_s2_c, r_s3_c, r_s4_c, r_s5_c;
    logic signed [W:0] r_s1_a1, r_s1_b1, r_s1_a2, r_s1_b2;
    logic signed [W:0] r_s2_a1, r_s2_b1, r_s2_a2, r_s2_b2;
    logic signed [W:0] r_s3_a1, r_s3_b1, r_s3_a2, r_s3_b2;
    logic signed [2*W:0]   r_s2_pa1, r_s2_pb1, r_s2_pa2, r_s2_pb2;
    logic signed [2*W+1:0] r_s2_pd1, r_s2_pd2;
    logic signed [CW-1:0]  r_s3_c1, r_s3_c2;
    logic signed [DW-1:0]  r_s3_d, r_s4_d, r_s5_d;
    logic signed [2*W+1:0] r_s4_b2c1h, r_s4_b1c2h, r_s4_a1c2h, r_s4_a2c1h;
    logic signed [2*W+2:0] r_s4_b2c1l, r_s4_b1c2l, r_s4_a1c2l, r_s4_a2c1l;
    logic signed [NW-1:0]  r_s5_nx, r_s5_ny;
    t_div r_s6;

    // flow control: a stage moves when empty or when the next one moves
    always_comb begin
        mv[NS-1] = !r_v[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            mv[k] = !r_v[k] || mv[k+1];
        end
    end

    assign o_ready = mv[0];
    assign o_valid = r_v[NS-1];
    assign o_data  = r_s6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (mv[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (mv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 1: direction terms
    always_ff @(posedge i_clk) begin
        if (mv[0]) begin
            r_s1_c  <= i_c;
            r_s1_a1 <= $signed({i_c[3][W-1], i_c[3]}) - $signed({i_c[1][W-1], i_c[1]});
            r_s1_b1 <= $signed({i_c[0][W-1], i_c[0]}) - $signed({i_c[2][W-1], i_c[2]});
            r_s1_a2 <= $signed({i_c[7][W-1], i_c[7]}) - $signed({i_c[5][W-1], i_c[5]});
            r_s1_b2 <= $signed({i_c[4][W-1], i_c[4]}) - $signed({i_c[6][W-1], i_c[6]});
        end
    end

    // stage 2: products for C and the determinant
    always_ff @(posedge i_clk) begin
        if (mv[1]) begin
            r_s2_c   <= r_s1_c;
            r_s2_a1  <= r_s1_a1;
            r_s2_b1  <= r_s1_b1;
            r_s2_a2  <= r_s1_a2;
            r_s2_b2  <= r_s1_b2;
            r_s2_pa1 <= r_s1_a1 * $signed(r_s1_c[0]);
            r_s2_pb1 <= r_s1_b1 * $signed(r_s1_c[1]);
            r_s2_pa2 <= r_s1_a2 * $signed(r_s1_c[4]);
            r_s2_pb2 <= r_s1_b2 * $signed(r_s1_c[5]);
            r_s2_pd1 <= r_s1_a1 * r_s1_b2;
            r_s2_pd2 <= r_s1_a2 * r_s1_b1;
        end
    end

    // stage 3: sum C terms, form the determinant
    always_ff @(posedge i_clk) begin
        if (mv[2]) begin
            r_s3_c  <= r_s2_c;
            r_s3_a1 <= r_s2_a1;
            r_s3_b1 <= r_s2_b1;
            r_s3_a2 <= r_s2_a2;
            r_s3_b2 <= r_s2_b2;
            r_s3_c1 <= CW'(r_s2_pa1) + CW'(r_s2_pb1);
            r_s3_c2 <= CW'(r_s2_pa2) + CW'(r_s2_pb2);
            r_s3_d  <= DW'(r_s2_pd1) - DW'(r_s2_pd2);
        end
    end

    // stage 4: numerator partial products, C split in high and low halves
    logic signed [W:0]   c1h, c2h;
    logic signed [W+1:0] c1l, c2l;
    assign c1h = r_s3_c1[CW-1:L];
    assign c2h = r_s3_c2[CW-1:L];
    assign c1l = $signed({1'b0, r_s3_c1[L-1:0]});
    assign c2l = $signed({1'b0, r_s3_c2[L-1:0]});

    always_ff @(posedge i_clk) begin
        if (mv[3]) begin
            r_s4_c     <= r_s3_c;
            r_s4_d     <= r_s3_d;
            r_s4_b2c1h <= r_s3_b2 * c1h;
            r_s4_b1c2h <= r_s3_b1 * c2h;
            r_s4_a1c2h <= r_s3_a1 * c2h;
            r_s4_a2c1h <= r_s3_a2 * c1h;
            r_s4_b2c1l <= r_s3_b2 * c1l;
            r_s4_b1c2l <= r_s3_b1 * c2l;
            r_s4_a1c2l <= r_s3_a1 * c2l;
            r_s4_a2c1l <= r_s3_a2 * c1l;
        end
    end

    // stage 5: combine partials into the numerators
    logic signed [NW-1:0] b2c1, b1c2, a1c2, a2c1;
    assign b2c1 = (NW'(r_s4_b2c1h) <<< L) + NW'(r_s4_b2c1l);
    assign b1c2 = (NW'(r_s4_b1c2h) <<< L) + NW'(r_s4_b1c2l);
    assign a1c2 = (NW'(r_s4_a1c2h) <<< L) + NW'(r_s4_a1c2l);
    assign a2c1 = (NW'(r_s4_a2c1h) <<< L) + NW'(r_s4_a2c1l);

    always_ff @(posedge i_clk) begin
        if (mv[4]) begin
            r_s5_c  <= r_s4_c;
            r_s5_d  <= r_s4_d;
            r_s5_nx <= b2c1 - b1c2;
            r_s5_ny <= a1c2 - a2c1;
        end
    end

    // stage 6: magnitudes, signs, range check, divisor alignment
    logic          dn, xn, yn;
    logic [DW-1:0] ad;
    logic [NW-1:0] ax, ay, dlim;
    assign dn   = r_s5_d[DW-1];
    assign xn   = r_s5_nx[NW-1];
    assign yn   = r_s5_ny[NW-1];
    assign ad   = dn ? DW'(-r_s5_d) : DW'(r_s5_d);
    assign ax   = xn ? NW'(-r_s5_nx) : NW'(r_s5_nx);
    assign ay   = yn ? NW'(-r_s5_ny) : NW'(r_s5_ny);
    assign dlim = NW'({ad, {W{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (mv[5]) begin
            r_s6.c  <= r_s5_c;
            r_s6.dz <= (r_s5_d == '0);
            r_s6.sx <= xn ^ dn;
            r_s6.sy <= yn ^ dn;
            r_s6.ox <= (ax >= dlim);
            r_s6.oy <= (ay >= dlim);
            r_s6.ds <= NW'(ad) << (W - 1);
            r_s6.px <= ax;
            r_s6.py <= ay;
            r_s6.qx <= '0;
            r_s6.qy <= '0;
        end
    end

endmodule

FILE: rtl/sgi_div_cell.sv
// ----------------------------------------------------------------------------
// sgi_div_cell: one restoring division step for X and Y
// Compares both partial remainders with the aligned divisor, shifts in one
// quotient bit each and hands the word to the next cell.
// ----------------------------------------------------------------------------
module sgi_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sgi_pkg::t_div i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output sgi_pkg::t_div o_data
);
    import sgi_pkg::*;

    logic r_v;
    t_div r_d;
    t_div n_d;
    logic gx, gy;

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_data  = r_d;

    // one quotient bit per coordinate
    always_comb begin
        gx    = i_data.px >= i_data.ds;
        gy    = i_data.py >= i_data.ds;
        n_d   = i_data;
        n_d.px = gx ? i_data.px - i_data.ds : i_data.px;
        n_d.py = gy ? i_data.py - i_data.ds : i_data.py;
        n_d.qx = {i_data.qx[W-2:0], gx};
        n_d.qy = {i_data.qy[W-2:0], gy};
        n_d.ds = i_data.ds >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_d <= n_d;
        end
    end

endmodule

FILE: rtl/sgi_back.sv
// ----------------------------------------------------------------------------
// sgi_back: span test and result register
// Rebuilds floor and ceiling of the exact point from quotient and remainder,
// checks both segments' spans and holds the result for transfer.
// ----------------------------------------------------------------------------
module sgi_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sgi_pkg::t_div i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output logic          o_hit,
    output logic [sgi_pkg::W-1:0] o_cross_x,
    output logic [sgi_pkg::W-1:0] o_cross_y
);
    import sgi_pkg::*;

    // exact value with given floor and ceiling inside a non-constant span
    function automatic logic in_span(input logic signed [W+1:0] fl,
                                     input logic signed [W+1:0] cl,
                                     input logic [W-1:0] e0,
                                     input logic [W-1:0] e1,
                                     input logic ovf);
        logic signed [W+1:0] x0, x1, lo, hi;
        x0 = $signed({{2{e0[W-1]}}, e0});
        x1 = $signed({{2{e1[W-1]}}, e1});
        lo = (x0 < x1) ? x0 : x1;
        hi = (x0 < x1) ? x1 : x0;
        return (e0 != e1) && !ovf && (fl >= lo) && (cl <= hi);
    endfunction

    logic                r_v;
    logic                r_hit;
    logic [W-1:0]        r_x, r_y;
    logic signed [W+1:0] tx, ty, flx, fly, clx, cly;
    logic                rx, ry, hit;

    // truncated quotients, then floor and ceiling from the remainder
    always_comb begin
        tx  = i_data.sx ? -$signed({2'b00, i_data.qx}) : $signed({2'b00, i_data.qx});
        ty  = i_data.sy ? -$signed({2'b00, i_data.qy}) : $signed({2'b00, i_data.qy});
        rx  = |i_data.px;
        ry  = |i_data.py;
        flx = tx - $signed({{(W+1){1'b0}}, i_data.sx & rx});
        clx = tx + $signed({{(W+1){1'b0}}, !i_data.sx & rx});
        fly = ty - $signed({{(W+1){1'b0}}, i_data.sy & ry});
        cly = ty + $signed({{(W+1){1'b0}}, !i_data.sy & ry});
        hit = !i_data.dz
            && (in_span(flx, clx, i_data.c[0], i_data.c[2], i_data.ox)
                || in_span(fly, cly, i_data.c[1], i_data.c[3], i_data.oy))
            && (in_span(flx, clx, i_data.c[4], i_data.c[6], i_data.ox)
                || in_span(fly, cly, i_data.c[5], i_data.c[7], i_data.oy));
    end

    assign o_ready   = !r_v || i_ready;
    assign o_valid   = r_v;
    assign o_hit     = r_hit;
    assign o_cross_x = r_x;
    assign o_cross_y = r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    // hold the result; zero coordinates without a hit
    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_hit <= hit;
            r_x   <= hit ? tx[W-1:0] : '0;
            r_y   <= hit ? ty[W-1:0] : '0;
        end
    end

endmodule

FILE: rtl/segment_intersection_2d.sv
// ----------------------------------------------------------------------------
// segment_intersection_2d: intersection point of two 2D segments
// Front stages form line terms and numerators, a chain of division cells
// yields one quotient bit per cell, a back stage tests spans.
// ----------------------------------------------------------------------------
// Stages: 6 front stages, 24 division cells and 1 output register from input transfer to result.
// Throughput: one segment pair per cycle while the output is not stalled; every stage and cell is registered.
// Each division cell settles one quotient bit, so the chain is as long as a
// coordinate is wide. Reset clears only the valid flags of all stages.
module segment_intersection_2d (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y,
    // b_end_x, b_end_y, 24 bits each from the lowest bit up
    input  logic [191:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // hit [0], cross_x [24:1], cross_y [48:25], zero fill [55:49]
    output logic [55:0]  m_axis_tdata
);
    import sgi_pkg::*;

    t_coords c_in;
    t_div    w_data [W+1];
    logic    w_valid [W+1];
    logic    w_ready [W+1];
    logic    hit;
    logic [W-1:0] cx, cy;

    // unpack the eight coordinates
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            c_in[k] = s_axis_tdata[k*W +: W];
        end
    end

    sgi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_c     (c_in),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_data  (w_data[0])
    );

    // divider chain, one quotient bit per cell
    for (genvar g = 0; g < W; g++) begin : g_cell
        sgi_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_data  (w_data[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_data  (w_data[g+1])
        );
    end

    sgi_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_valid[W]),
        .o_ready   (w_ready[W]),
        .i_data    (w_data[W]),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_hit     (hit),
        .o_cross_x (cx),
        .o_cross_y (cy)
    );

    assign m_axis_tdata = {7'b0, cy, cx, hit};

endmodule

FILE: tb/segment_intersection_2d_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segment_intersection_2d_tb: self-checking bench for the segment intersector
// Drives segment pairs over the input stream under several idle and stall
// phases, predicts each result with exact wide arithmetic unless a directed
// row gives it, and compares the output stream in order.
// ----------------------------------------------------------------------------
module segment_intersection_2d_tb;

    import sgi_pkg::*;

    localparam int    MAXC    = (1 << (W - 1)) - 1;
    localparam int    MINC    = -(1 << (W - 1));
    localparam int    LATENCY = 31;
    localparam longint LIMIT  = 400000;

    typedef struct packed {
        logic         hit;
        logic [W-1:0] cx;
        logic [W-1:0] cy;
    } t_cross;

    typedef struct {
        int  c[8];
        bit  known;
        bit  hit;
        int  cx;
        int  cy;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
    logic [191:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // hit, cross_x, cross_y, zero fill
    logic [55:0]  m_axis_tdata;

    t_cross  crossing_q[$];
    int      errors = 0;
    longint  cycles = 0;
    int      send_idle;
    int      recv_stall;
    t_row    rows[$];

    segment_intersection_2d dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // exact n/d inside the closed, non-constant span e0..e1 (d positive)
    function automatic bit on_span(logic signed [127:0] n, logic signed [127:0] d,
                                   int e0, int e1);
        logic signed [127:0] lo;
        logic signed [127:0] hi;
        if (e0 == e1) return 1'b0;
        lo = (e0 < e1) ? e0 : e1;
        hi = (e0 < e1) ? e1 : e0;
        return (n >= lo * d) && (n <= hi * d);
    endfunction

    // intersection point of segment pair p
    function automatic t_cross predict_cross(int p[8]);
        logic signed [127:0] a1, b1, c1, a2, b2, c2, d, nx, ny, qx, qy;
        t_cross r;
        r = '0;
        a1 = p[3] - p[1];
        b1 = p[0] - p[2];
        c1 = a1 * p[0] + b1 * p[1];
        a2 = p[7] - p[5];
        b2 = p[4] - p[6];
        c2 = a2 * p[4] + b2 * p[5];
        d  = a1 * b2 - a2 * b1;
        if (d == 0) return r;
        nx = b2 * c1 - b1 * c2;
        ny = a1 * c2 - a2 * c1;
        if (d < 0) begin
            d = -d;
            nx = -nx;
            ny = -ny;
        end
        if (!((on_span(nx, d, p[0], p[2]) || on_span(ny, d, p[1], p[3])) &&
              (on_span(nx, d, p[4], p[6]) || on_span(ny, d, p[5], p[7]))))
            return r;
        // signed division truncates toward zero
        qx = nx / d;
        qy = ny / d;
        r.hit = 1'b1;
        r.cx  = qx[W-1:0];
        r.cy  = qy[W-1:0];
        return r;
    endfunction

    function automatic int rand_coord(int mode);
        case (mode)
            0: return $signed($urandom()) >>> (32 - W);
            1: return $urandom_range(0, 4000) - 2000;
            default: return ($urandom_range(0, 1) != 0) ? MAXC : MINC;
        endcase
    endfunction

    task automatic add_row(int p0, int p1, int p2, int p3, int p4, int p5, int p6, int p7,
                           bit known, bit hit, int cx, int cy);
        t_row r;
        r.c = '{p0, p1, p2, p3, p4, p5, p6, p7};
        r.known = known;
        r.hit = hit;
        r.cx = cx;
        r.cy = cy;
        rows = {rows, r};
    endtask

    // hold one segment pair until its transfer
    task automatic send_pair(int p[8], bit known, t_cross given);
        t_cross exp_c;
        int     pw[8];
        while (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        // only the low coordinate bits travel; predict from what is sent
        for (int k = 0; k < 8; k++)
            pw[k] = {{(32 - W){p[k][W-1]}}, p[k][W-1:0]};
        exp_c = known ? given : predict_cross(pw);
        for (int k = 0; k < 8; k++)
            s_axis_tdata[k*W +: W] <= pw[k][W-1:0];
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        crossing_q = {crossing_q, exp_c};
    endtask

    task automatic random_pair();
        int p[8];
        int mode;
        int m;
        mode = $urandom_range(0, 9);
        for (int k = 0; k < 8; k++) begin
            m = (mode < 4) ? 0 : (mode < 9) ? 1 : $urandom_range(0, 2);
            p[k] = rand_coord(m);
        end
        // force some shared endpoints, axis-aligned and parallel pairs
        case ($urandom_range(0, 7))
            0: begin
                p[4] = p[2];
                p[5] = p[3];
            end
            1: begin
                p[2] = p[0];
                p[7] = p[5];
            end
            2: begin
                p[6] = p[4] + (p[2] - p[0]) / 2;
                p[7] = p[5] + (p[3] - p[1]) / 2;
            end
            default: ;
        endcase
        send_pair(p, 1'b0, '0);
    endtask

    // receiver: stall at random, compare every transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_cross got;
        t_cross exp_c;
        cycles <= cycles + 1;
        if (i_rst_n) begin
            m_axis_tready <= !(recv_stall > 0 && $urandom_range(0, 99) < recv_stall);
            if (m_axis_tvalid && m_axis_tready) begin
                got.hit = m_axis_tdata[0];
                got.cx  = m_axis_tdata[24:1];
                got.cy  = m_axis_tdata[48:25];
                if (crossing_q.size() == 0) begin
                    $error("unexpected result transfer %h", m_axis_tdata);
                    errors++;
                end else begin
                    exp_c = crossing_q.pop_front();
                    if (got.hit !== exp_c.hit) begin
                        $error("hit: expected %0d, got %0d", exp_c.hit, got.hit);
                        errors++;
                    end
                    if (got.cx !== exp_c.cx) begin
                        $error("cross_x: expected %h, got %h", exp_c.cx, got.cx);
                        errors++;
                    end
                    if (got.cy !== exp_c.cy) begin
                        $error("cross_y: expected %h, got %h", exp_c.cy, got.cy);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (cycles > LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_cross given;
        int p[8];
        int hold;
        send_idle = 0;
        recv_stall = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: crossing diagonals, parallel, degenerate, touching ends, extremes
        add_row(0, 0, 512, 512, 0, 512, 512, 0, 1'b1, 1'b1, 256, 256);
        add_row(0, 0, 256, 0, 0, 256, 256, 256, 1'b1, 1'b0, 0, 0);
        add_row(0, 0, 512, 512, 256, 256, 768, 768, 1'b1, 1'b0, 0, 0);
        add_row(5, 5, 5, 5, 0, 0, 100, 100, 1'b1, 1'b0, 0, 0);
        add_row(0, 0, 256, 0, 256, 0, 256, 256, 1'b1, 1'b1, 256, 0);
        add_row(0, 0, 256, 0, 300, -10, 300, 10, 1'b1, 1'b0, 0, 0);
        add_row(MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC, 1'b0, 1'b0, 0, 0);
        add_row(MINC, 0, MAXC, 0, 0, MINC, 0, MAXC, 1'b1, 1'b1, 0, 0);
        add_row(MAXC, MAXC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, 1'b1, 1'b1, MAXC, MAXC);
        add_row(MINC, MINC, MAXC, MINC, MINC, MAXC, MINC, MINC, 1'b1, 1'b1, MINC, MINC);
        add_row(0, 0, 3, 1, 0, 1, 3, 0, 1'b0, 1'b0, 0, 0);
        add_row(0, 0, -3, 1, 0, 1, -3, 0, 1'b0, 1'b0, 0, 0);
        add_row(-1, -1, -1, -1, -1, -1, -1, -1, 1'b1, 1'b0, 0, 0);
        add_row(0, -7, 0, 7, -5, 3, 9, -2, 1'b0, 1'b0, 0, 0);
        foreach (rows[i]) begin
            given.hit = rows[i].hit;
            given.cx  = rows[i].cx[W-1:0];
            given.cy  = rows[i].cy[W-1:0];
            p = rows[i].c;
            send_pair(p, rows[i].known, given);
        end

        // random phases: free flow, idle sender, stalled receiver, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle  = (ph == 1) ? 65 : (ph == 3) ? 17 : 0;
            recv_stall = (ph == 2) ? 65 : (ph == 3) ? 17 : 0;
            for (int i = 0; i < 100; i++)
                random_pair();
        end
        s_axis_tvalid <= 1'b0;
        recv_stall = 0;

        hold = 0;
        while (crossing_q.size() != 0)
            @(posedge i_clk);
        while (hold < 2 * LATENCY) begin
            @(posedge i_clk);
            hold++;
        end
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
